/* rtl/core/qts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qts_pkg: shared types and constants of the query token scanner
// Token kinds, error codes, the queue entry layout and the keyword prefix
// table with its lookup function.
// ----------------------------------------------------------------------------
package qts_pkg;

	localparam int PREFIX_DEPTH = 6;
	localparam int PREFIX_W     = 8 * PREFIX_DEPTH;
	localparam int QUEUE_DEPTH  = 4;
	localparam int LENGTH_BITS_DEFAULT = 12;

	localparam logic [4:0] KIND_HOOK   = 5'd0;
	localparam logic [4:0] KIND_KEY    = 5'd1;
	localparam logic [4:0] KIND_TABLE  = 5'd2;
	localparam logic [4:0] KIND_KVALOT = 5'd3;
	localparam logic [4:0] KIND_LIST   = 5'd4;
	localparam logic [4:0] KIND_BITMAP = 5'd5;
	localparam logic [4:0] KIND_STREAM = 5'd6;
	localparam logic [4:0] KIND_SET    = 5'd7;
	localparam logic [4:0] KIND_INSERT = 5'd8;
	localparam logic [4:0] KIND_ADD    = 5'd9;
	localparam logic [4:0] KIND_FIELD  = 5'd10;
	localparam logic [4:0] KIND_LINE   = 5'd11;
	localparam logic [4:0] KIND_RANK   = 5'd12;
	localparam logic [4:0] KIND_NAME   = 5'd13;
	localparam logic [4:0] KIND_AT     = 5'd14;
	localparam logic [4:0] KIND_ALTER  = 5'd15;
	localparam logic [4:0] KIND_NUMBER = 5'd16;
	localparam logic [4:0] KIND_STRING = 5'd17;
	localparam logic [4:0] KIND_CHAR   = 5'd18;
	localparam logic [4:0] KIND_END    = 5'd19;
	localparam logic [4:0] KIND_ERROR  = 5'd20;

	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_CHAR       = 3'd1;
	localparam logic [2:0] ERR_STRING_EOF = 3'd2;
	localparam logic [2:0] ERR_WORD_EOF   = 3'd3;
	localparam logic [2:0] ERR_NUMBER     = 3'd4;

	typedef struct packed {
		logic [4:0]  kind;
		logic [11:0] length;
		logic        sat;
		logic [7:0]  chr;
		logic [2:0]  err;
	} result_t;

	// one accepted byte worth of results: one, or two when pair is set
	typedef struct packed {
		logic    pair;
		result_t first;
		result_t second;
	} entry_t;

	typedef struct packed {
		logic empty;
		logic full;
	} queue_status_t;

	typedef struct packed {
		logic [PREFIX_W-1:0] text;   // left aligned, first byte on top
		logic [2:0]          len;
		logic [4:0]          kind;
	} kw_entry_t;

	typedef struct packed {
		logic       hit;
		logic [4:0] kind;
	} kw_hit_t;

	localparam int KW_COUNT = 31;

	// listed in priority order, earliest entry wins
	localparam kw_entry_t KW_TABLE [KW_COUNT] = '{
		'{{"SET", 24'd0},    3'd3, KIND_SET},
		'{{"set", 24'd0},    3'd3, KIND_SET},
		'{"INSERT",          3'd6, KIND_INSERT},
		'{"insert",          3'd6, KIND_INSERT},
		'{{"ADD", 24'd0},    3'd3, KIND_ADD},
		'{{"add", 24'd0},    3'd3, KIND_ADD},
		'{{"AT", 32'd0},     3'd2, KIND_AT},
		'{{"at", 32'd0},     3'd2, KIND_AT},
		'{{"ALTER", 8'd0},   3'd5, KIND_ALTER},
		'{{"alter", 8'd0},   3'd5, KIND_ALTER},
		'{{"TABLE", 8'd0},   3'd5, KIND_TABLE},
		'{{"table", 8'd0},   3'd5, KIND_TABLE},
		'{"KEYLOT",          3'd6, KIND_KVALOT},
		'{"kvalot",          3'd6, KIND_KVALOT},
		'{"keylot",          3'd6, KIND_KVALOT},
		'{{"LIST", 16'd0},   3'd4, KIND_LIST},
		'{{"list", 16'd0},   3'd4, KIND_LIST},
		'{"BITMAP",          3'd6, KIND_BITMAP},
		'{"bitmap",          3'd6, KIND_BITMAP},
		'{"STREAM",          3'd6, KIND_STREAM},
		'{"stream",          3'd6, KIND_STREAM},
		'{{"FIELD", 8'd0},   3'd5, KIND_FIELD},
		'{{"field", 8'd0},   3'd5, KIND_FIELD},
		'{{"LINE", 16'd0},   3'd4, KIND_LINE},
		'{{"line", 16'd0},   3'd4, KIND_LINE},
		'{{"RANK", 16'd0},   3'd4, KIND_RANK},
		'{{"rank", 16'd0},   3'd4, KIND_RANK},
		'{{"HOOK", 16'd0},   3'd4, KIND_HOOK},
		'{{"hook", 16'd0},   3'd4, KIND_HOOK},
		'{{"KEY", 24'd0},    3'd3, KIND_KEY},
		'{{"key", 24'd0},    3'd3, KIND_KEY}
	};

	// have: word length clipped to 7
	function automatic kw_hit_t kw_lookup(input logic [PREFIX_W-1:0] pfx,
	                                      input logic [2:0] have);
		kw_hit_t             res;
		logic [PREFIX_W-1:0] mask;
		res = '0;
		for (int k = KW_COUNT - 1; k >= 0; k--) begin
			mask = ~({PREFIX_W{1'b1}} >> (8 * int'(KW_TABLE[k].len)));
			if ((have >= KW_TABLE[k].len) &&
			    (((pfx ^ KW_TABLE[k].text) & mask) == '0)) begin
				res.hit  = 1'b1;
				res.kind = KW_TABLE[k].kind;
			end
		end
		return res;
	endfunction

endpackage

/* rtl/core/qts_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qts_front: byte scanner
// Advances the token state by one byte per transfer and packs the results
// that the byte causes into one queue entry.
// ----------------------------------------------------------------------------
module qts_front import qts_pkg::*; #(
	parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_fire,
	input  logic [7:0] text_byte,
	input  logic       last_byte,
	output logic       push,
	output entry_t     push_data
);

	localparam logic [2:0] MODE_SEEK     = 3'd0;
	localparam logic [2:0] MODE_WORD     = 3'd1;
	localparam logic [2:0] MODE_STRING   = 3'd2;
	localparam logic [2:0] MODE_CH_OPEN  = 3'd3;
	localparam logic [2:0] MODE_CH_ESC   = 3'd4;
	localparam logic [2:0] MODE_CH_CLOSE = 3'd5;
	localparam logic [2:0] MODE_DRAIN    = 3'd6;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic starts_word(input logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
		       is_digit(c) || c[7] || (c == "_") || (c == 8'h0A);
	endfunction

	function automatic result_t mk(input logic [4:0] k, input logic [11:0] l,
	                               input logic s, input logic [7:0] c,
	                               input logic [2:0] e);
		result_t r;
		r.kind   = k;
		r.length = l;
		r.sat    = s;
		r.chr    = c;
		r.err    = e;
		return r;
	endfunction

	logic [2:0]             mode_q, mode_n;
	logic [LENGTH_BITS-1:0] run_q, run_n;
	logic                   over_q, over_n;
	logic [PREFIX_W-1:0]    pfx_q, pfx_n;
	logic [7:0]             prev_q, prev_n;
	logic                   numok_q, numok_n;
	logic [7:0]             lit_q, lit_n;

	// word byte update, from a fresh run or the current one
	logic                   fresh;
	logic [LENGTH_BITS-1:0] base_run, wb_run;
	logic                   base_over, wb_over;
	logic [PREFIX_W-1:0]    base_pfx, wb_pfx;
	logic                   base_ok, wb_ok;

	logic [LENGTH_BITS+11:0] run_wide;
	logic [11:0]             len12;
	logic [2:0]              have;
	kw_hit_t                 kw;
	logic [4:0]              word_kind;
	logic                    word_bad;

	logic [1:0] n_res;
	result_t    res0, res1;
	logic [7:0] esc_val;
	logic       esc_ok;

	assign fresh = (mode_q != MODE_WORD) && (mode_q != MODE_STRING);

	always_comb begin
		base_run  = fresh ? '0 : run_q;
		base_over = fresh ? 1'b0 : over_q;
		base_pfx  = fresh ? '0 : pfx_q;
		base_ok   = fresh ? 1'b1 : numok_q;
		wb_pfx    = base_pfx;
		if (base_run < LENGTH_BITS'(PREFIX_DEPTH)) begin
			wb_pfx[8 * (PREFIX_DEPTH - 1 - int'(base_run[2:0])) +: 8] = text_byte;
		end
		wb_ok = base_ok && (is_digit(text_byte) || (text_byte == "."));
		if (&base_run) begin
			wb_run  = base_run;
			wb_over = 1'b1;
		end else begin
			wb_run  = base_run + LENGTH_BITS'(1);
			wb_over = base_over;
		end
	end

	assign run_wide = {12'd0, run_q};
	assign len12    = run_wide[11:0];
	assign have     = (run_q > LENGTH_BITS'(7)) ? 3'd7 : run_q[2:0];
	assign kw       = kw_lookup(pfx_q, have);

	always_comb begin
		word_bad = 1'b0;
		if (kw.hit) begin
			word_kind = kw.kind;
		end else if (is_digit(pfx_q[PREFIX_W-1 -: 8])) begin
			word_kind = numok_q ? KIND_NUMBER : KIND_ERROR;
			word_bad  = !numok_q;
		end else begin
			word_kind = KIND_NAME;
		end
	end

	always_comb begin
		esc_ok = 1'b1;
		unique case (text_byte)
			"n":       esc_val = 8'd10;
			"t":       esc_val = 8'd9;
			"r":       esc_val = 8'd13;
			"0":       esc_val = 8'd0;
			CH_BSLASH: esc_val = 8'd92;
			default: begin
				esc_val = lit_q;
				esc_ok  = 1'b0;
			end
		endcase
	end

	always_comb begin
		mode_n  = mode_q;
		run_n   = run_q;
		over_n  = over_q;
		pfx_n   = pfx_q;
		prev_n  = prev_q;
		numok_n = numok_q;
		lit_n   = lit_q;
		n_res   = 2'd0;
		res0    = '0;
		res1    = '0;
		unique case (mode_q)
			MODE_DRAIN: begin
			end
			MODE_WORD: begin
				if ((text_byte == CH_SPACE) || (text_byte == CH_SEMI)) begin
					if (word_bad) begin
						res0   = mk(KIND_ERROR, 12'd0, 1'b0, 8'd0, ERR_NUMBER);
						n_res  = 2'd1;
						mode_n = MODE_DRAIN;
					end else begin
						res0   = mk(word_kind, len12, over_q, 8'd0, ERR_NONE);
						n_res  = 2'd1;
						mode_n = MODE_SEEK;
						if (text_byte == CH_SEMI) begin
							res1  = mk(KIND_END, 12'd0, 1'b0, 8'd0, ERR_NONE);
							n_res = 2'd2;
						end
					end
				end else begin
					run_n   = wb_run;
					over_n  = wb_over;
					pfx_n   = wb_pfx;
					numok_n = wb_ok;
					if (last_byte) begin
						res0   = mk(KIND_ERROR, 12'd0, 1'b0, 8'd0, ERR_WORD_EOF);
						n_res  = 2'd1;
						mode_n = MODE_DRAIN;
					end
				end
			end
			MODE_STRING: begin
				if ((text_byte == CH_DQUOTE) && (prev_q != CH_BSLASH)) begin
					res0   = mk(KIND_STRING, len12, over_q, 8'd0, ERR_NONE);
					n_res  = 2'd1;
					mode_n = MODE_SEEK;
				end else begin
					run_n  = wb_run;
					over_n = wb_over;
					prev_n = text_byte;
					if (last_byte) begin
						res0   = mk(KIND_ERROR, 12'd0, 1'b0, 8'd0, ERR_STRING_EOF);
						n_res  = 2'd1;
						mode_n = MODE_DRAIN;
					end
				end
			end
			MODE_CH_OPEN: begin
				if (text_byte == CH_BSLASH) begin
					mode_n = MODE_CH_ESC;
				end else begin
					lit_n  = text_byte;
					mode_n = MODE_CH_CLOSE;
				end
				if (last_byte) begin
					res0   = mk(KIND_ERROR, 12'd0, 1'b0, 8'd0, ERR_CHAR);
					n_res  = 2'd1;
					mode_n = MODE_DRAIN;
				end
			end
			MODE_CH_ESC: begin
				lit_n = esc_val;
				if (!esc_ok || last_byte) begin
					res0   = mk(KIND_ERROR, 12'd0, 1'b0, 8'd0, ERR_CHAR);
					n_res  = 2'd1;
					mode_n = MODE_DRAIN;
				end else begin
					mode_n = MODE_CH_CLOSE;
				end
			end
			MODE_CH_CLOSE: begin
				if (text_byte == CH_SQUOTE) begin
					res0   = mk(KIND_CHAR, 12'd1, 1'b0, lit_q, ERR_NONE);
					n_res  = 2'd1;
					mode_n = MODE_SEEK;
				end else begin
					res0   = mk(KIND_ERROR, 12'd0, 1'b0, 8'd0, ERR_CHAR);
					n_res  = 2'd1;
					mode_n = MODE_DRAIN;
				end
			end
			default: begin
				// seeking a token start; the spare code lands here too
				mode_n = MODE_SEEK;
				if (text_byte == CH_DQUOTE) begin
					run_n   = '0;
					over_n  = 1'b0;
					pfx_n   = '0;
					numok_n = 1'b1;
					prev_n  = CH_DQUOTE;
					mode_n  = MODE_STRING;
					if (last_byte) begin
						res0   = mk(KIND_ERROR, 12'd0, 1'b0, 8'd0, ERR_STRING_EOF);
						n_res  = 2'd1;
						mode_n = MODE_DRAIN;
					end
				end else if (text_byte == CH_SQUOTE) begin
					mode_n = MODE_CH_OPEN;
					if (last_byte) begin
						res0   = mk(KIND_ERROR, 12'd0, 1'b0, 8'd0, ERR_CHAR);
						n_res  = 2'd1;
						mode_n = MODE_DRAIN;
					end
				end else if (text_byte == CH_SEMI) begin
					res0  = mk(KIND_END, 12'd0, 1'b0, 8'd0, ERR_NONE);
					n_res = 2'd1;
				end else if (starts_word(text_byte)) begin
					run_n   = wb_run;
					over_n  = wb_over;
					pfx_n   = wb_pfx;
					numok_n = wb_ok;
					mode_n  = MODE_WORD;
					if (last_byte) begin
						res0   = mk(KIND_ERROR, 12'd0, 1'b0, 8'd0, ERR_WORD_EOF);
						n_res  = 2'd1;
						mode_n = MODE_DRAIN;
					end
				end
			end
		endcase
		if (last_byte) begin
			mode_n = MODE_SEEK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_SEEK;
			run_q   <= '0;
			over_q  <= 1'b0;
			pfx_q   <= '0;
			prev_q  <= 8'd0;
			numok_q <= 1'b1;
			lit_q   <= 8'd0;
		end else if (in_fire) begin
			mode_q  <= mode_n;
			run_q   <= run_n;
			over_q  <= over_n;
			pfx_q   <= pfx_n;
			prev_q  <= prev_n;
			numok_q <= numok_n;
			lit_q   <= lit_n;
		end
	end

	assign push             = in_fire && (n_res != 2'd0);
	assign push_data.pair   = (n_res == 2'd2);
	assign push_data.first  = res0;
	assign push_data.second = res1;

endmodule

/* rtl/core/qts_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qts_queue: entry queue between scanner and emitter
// Small first-in first-out store of result entries with fill status.
// ----------------------------------------------------------------------------
module qts_queue import qts_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  entry_t        push_data,
	input  logic          pop,
	output entry_t        head,
	output queue_status_t status
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	entry_t           slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	assign head         = slots_q[rd_q];
	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == CNT_W'(QUEUE_DEPTH));

endmodule

/* rtl/core/qts_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qts_back: result emitter
// Unpacks queue entries into single results held in the output register.
// ----------------------------------------------------------------------------
module qts_back import qts_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  entry_t        head,
	input  queue_status_t status,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [4:0]    token_kind,
	output logic [11:0]   token_length,
	output logic          length_saturated,
	output logic [7:0]    char_value,
	output logic [2:0]    error_code,
	output logic          final_result
);

	logic    sub_q;
	logic    valid_q;
	result_t res_q;
	logic    final_q;

	logic    load, take, is_last;
	result_t sel;

	assign load    = !valid_q || !out_stall;
	assign take    = load && !status.empty;
	assign sel     = sub_q ? head.second : head.first;
	assign is_last = !head.pair || sub_q;
	assign pop     = take && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sub_q   <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= !status.empty;
			end
			if (take) begin
				sub_q <= !is_last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q   <= sel;
			final_q <= is_last;
		end
	end

	assign out_valid        = valid_q;
	assign token_kind       = res_q.kind;
	assign token_length     = res_q.length;
	assign length_saturated = res_q.sat;
	assign char_value       = res_q.chr;
	assign error_code       = res_q.err;
	assign final_result     = final_q;

endmodule

/* rtl/core/query_token_scanner.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// query_token_scanner: byte-serial query tokenizer
// Splits query text into words, keywords, numbers, strings, char literals
// and statement ends, one text byte per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one text byte per transfer,
//   with last_byte marking the final byte of a query. A transfer happens at
//   a rising edge with in_valid high and in_stall low.
//   Output channel (out_valid / out_stall) carries one token per transfer.
//   A byte causes zero, one or two tokens; final_result marks the last one.
// Throughput: one byte per cycle while the queue has room. The scanner state
//   updates once per byte, so bytes may follow back to back. The output
//   register emits one token per cycle while out_stall is low, so a byte
//   that ends a word with ';' yields two output tokens.
// Path: a byte's transfer writes its entry into the queue, and the emitter
//   then loads each token from the queue head into the output register.
// Stall: the scanner and the emitter are parted by a four-entry queue.
//   in_stall rises only while that queue is full; a stalled output holds
//   its token stable.
// Reset: arst_n clears the scanner to seeking a token start and empties the
//   queue and output register. No clearing pass is needed.
// ----------------------------------------------------------------------------
module query_token_scanner import qts_pkg::*; #(
	parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  text_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  token_kind,
	output logic [11:0] token_length,
	output logic        length_saturated,
	output logic [7:0]  char_value,
	output logic [2:0]  error_code,
	output logic        final_result
);

	logic          in_fire;
	logic          push, pop;
	entry_t        push_data, head;
	queue_status_t status;

	// hold the input off only while the queue has no room
	assign in_stall = status.full;
	assign in_fire  = in_valid && !in_stall;

	qts_front #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.text_byte (text_byte),
		.last_byte (last_byte),
		.push      (push),
		.push_data (push_data)
	);

	// decouple byte scanning from token delivery
	qts_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.status    (status)
	);

	// advance through the entry one token per output transfer
	qts_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.head             (head),
		.status           (status),
		.pop              (pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.token_kind       (token_kind),
		.token_length     (token_length),
		.length_saturated (length_saturated),
		.char_value       (char_value),
		.error_code       (error_code),
		.final_result     (final_result)
	);

endmodule

/* rtl/core/qts_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qts_checker: port-level checks of the query token scanner
// Watches the output channel for token ordering and field consistency.
// ----------------------------------------------------------------------------
module qts_checker import qts_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [4:0]  token_kind,
	input logic [11:0] token_length,
	input logic        length_saturated,
	input logic [7:0]  char_value,
	input logic [2:0]  error_code,
	input logic        final_result
);

	// stalled token holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(token_kind) &&
		$stable(token_length) && $stable(error_code) && $stable(final_result))
		else $error("output token changed while stalled");

	// end and error tokens always close their byte's results
	a_end_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((token_kind == KIND_END) || (token_kind == KIND_ERROR))
		|-> final_result)
		else $error("end or error token not marked final");

	// a non-final token is a word, and its end token follows at once
	a_pair_next: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !final_result
		|=> out_valid && (token_kind == KIND_END))
		else $error("second token of a pair missing");

	// error tokens carry a code and nothing else
	a_error_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (token_kind == KIND_ERROR)
		|-> (error_code != ERR_NONE) && (token_length == 12'd0) &&
		(char_value == 8'd0) && !length_saturated)
		else $error("error token fields inconsistent");

endmodule

bind query_token_scanner qts_checker u_qts_checker (.*);
